/* sv/ffea_pkg.sv */
package ffea_pkg;

  localparam int MAX_EXTENTS_DEF   = 64;
  localparam int GRANULE_BYTES_DEF = 16;
  localparam int REGION_BYTES_DEF  = 1048576;
  localparam int RESET_GRANULES    = 65536;

  localparam int CFG_W    = 17;
  localparam int SIZE_W   = 21;
  localparam int OFFSET_W = 20;
  localparam int STATUS_W = 2;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_ZERO  = 2'd3
  } ffea_status_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_ALLOC,
    CMD_PLACE,
    CMD_MERGE
  } ffea_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_PROBE,
    ST_PLACE,
    ST_MERGE,
    ST_DONE
  } ffea_state_e;

  // flags and prefix chains handed from a cell to its right neighbor
  typedef struct packed {
    logic valid;
    logic le;
    logic pm;
    logic mark;
    logic fitpre;
    logic rm;
    logic ins;
    logic del;
    logic merge_any;
    logic absorb_any;
  } ffea_flags_t;

endpackage

/* sv/ffea_cell.sv */
module ffea_cell
  import ffea_pkg::*;
#(
  parameter int LW       = 17,
  parameter bit IS_FIRST = 1'b0
) (
  input  logic          clk,
  input  logic          rst,
  input  ffea_cmd_e     cmd,
  input  logic [LW-1:0] init_len,
  input  logic [LW:0]   need,
  input  logic [LW-1:0] rel_s,
  input  logic [LW-1:0] rel_e,
  input  logic [LW-1:0] rel_len,
  input  ffea_flags_t   l_fl,
  input  logic [LW-1:0] l_start,
  input  logic [LW-1:0] l_len,
  input  logic          r_valid,
  input  logic [LW-1:0] r_start,
  input  logic [LW-1:0] r_len,
  input  logic [LW-1:0] sel_in,
  output ffea_flags_t   o_fl,
  output logic [LW-1:0] o_start,
  output logic [LW-1:0] o_len,
  output logic [LW-1:0] sel_out
);

  logic          v, v_next, mk, mk_next;
  logic [LW-1:0] st, st_next, ln, ln_next;
  logic [LW-1:0] en, l_end, r_end, top_e, top_r;
  logic          fit, first, exact, shl, le, r_le, pm, pos, nm, ins_here, absorb, grow;

  always_comb begin
    en     = st + ln;
    l_end  = l_start + l_len;
    r_end  = r_start + r_len;
    fit    = v && ({1'b0, ln} >= need);
    first  = fit && !l_fl.fitpre;
    exact  = ({1'b0, ln} == need);
    shl    = l_fl.rm || (first && exact);
    le     = v && (st <= rel_s);
    r_le   = r_valid && (r_start <= rel_s);
    pm     = le && !r_le && (en >= rel_s);
    pos    = !le && l_fl.le;
    nm     = pos && v && !l_fl.pm && (st <= rel_e);
    ins_here = pos && !l_fl.pm && !nm;
    absorb = l_fl.mark && v && (st <= l_end);
    grow   = mk && r_valid && (r_start <= en);
    top_e  = (en > rel_e) ? en : rel_e;
    top_r  = (r_end > en) ? r_end : en;
  end

  always_comb begin
    o_fl.valid      = v;
    o_fl.le         = le;
    o_fl.pm         = pm;
    o_fl.mark       = mk;
    o_fl.fitpre     = l_fl.fitpre || fit;
    o_fl.rm         = shl;
    o_fl.ins        = l_fl.ins || ins_here;
    o_fl.del        = l_fl.del || absorb;
    o_fl.merge_any  = l_fl.merge_any || pm || nm;
    o_fl.absorb_any = l_fl.absorb_any || absorb;
    o_start         = st;
    o_len           = ln;
    sel_out         = first ? st : sel_in;
  end

  always_comb begin
    v_next  = v;
    st_next = st;
    ln_next = ln;
    mk_next = mk;
    unique case (cmd)
      CMD_INIT: begin
        v_next  = IS_FIRST;
        st_next = '0;
        ln_next = init_len;
        mk_next = 1'b0;
      end
      CMD_ALLOC: begin
        mk_next = 1'b0;
        if (first && !exact) begin
          st_next = st + need[LW-1:0];
          ln_next = ln - need[LW-1:0];
        end else if (shl) begin
          v_next  = r_valid;
          st_next = r_start;
          ln_next = r_len;
        end
      end
      CMD_PLACE: begin
        mk_next = 1'b0;
        if (pm) begin
          ln_next = top_e - st;
          mk_next = 1'b1;
        end else if (nm) begin
          st_next = rel_s;
          ln_next = top_e - rel_s;
          mk_next = 1'b1;
        end else if (ins_here) begin
          v_next  = 1'b1;
          st_next = rel_s;
          ln_next = rel_len;
          mk_next = 1'b1;
        end else if (l_fl.ins) begin
          v_next  = l_fl.valid;
          st_next = l_start;
          ln_next = l_len;
        end
      end
      CMD_MERGE: begin
        if (grow) begin
          ln_next = top_r - st;
        end else if (l_fl.del || absorb) begin
          v_next  = r_valid;
          st_next = r_start;
          ln_next = r_len;
          mk_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= IS_FIRST;
      mk <= 1'b0;
      st <= '0;
      ln <= init_len;
    end else begin
      v  <= v_next;
      mk <= mk_next;
      st <= st_next;
      ln <= ln_next;
    end
  end

endmodule

/* sv/first_fit_extent_allocator_unit.sv */
// steps: an allocate passes ALLOC then DONE; a release passes PROBE, PLACE, then MERGE,
// repeated while neighbors are absorbed, then DONE; a release refused by a full table goes
// from PROBE to DONE; zero size or beyond region end goes straight to DONE. One request is in
// work at a time; the next is accepted once the result register loads, held in DONE while stalled
// reset (rst, synchronous): region set to 65536 granules clamped, one free extent covering it,
// no result pending; a region write re-initializes the table in the same cycle
module first_fit_extent_allocator_unit
  import ffea_pkg::*;
#(
  parameter int MAX_EXTENTS   = MAX_EXTENTS_DEF,
  parameter int GRANULE_BYTES = GRANULE_BYTES_DEF,
  parameter int REGION_BYTES  = REGION_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [SIZE_W-1:0]   size_bytes,
  input  logic [OFFSET_W-1:0] block_offset,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [OFFSET_W-1:0] granted_offset
);

  localparam int GL       = $clog2(GRANULE_BYTES);
  localparam int MAX_GRAN = REGION_BYTES / GRANULE_BYTES;
  localparam int LW       = $clog2(MAX_GRAN + 1);
  localparam int NW       = SIZE_W + 1 - GL;
  localparam int CW0      = (LW + 1 > NW) ? LW + 1 : NW;
  localparam int CW       = (CW0 > CFG_W) ? CW0 : CFG_W;
  localparam int PW       = (LW + GL > OFFSET_W) ? LW + GL : OFFSET_W;
  localparam int RESET_G  = (RESET_GRANULES > MAX_GRAN) ? MAX_GRAN : RESET_GRANULES;

  ffea_state_e state, state_next;
  ffea_cmd_e   cmd;

  logic [LW-1:0] region, init_len;
  logic [LW:0]   need_r;
  logic [LW-1:0] s_r, e_r, rlen_r;
  ffea_status_e  res_status;
  logic [OFFSET_W-1:0] res_off;

  // cell row wiring
  ffea_flags_t   fl [MAX_EXTENTS];
  logic [LW-1:0] cst [MAX_EXTENTS];
  logic [LW-1:0] cln [MAX_EXTENTS];
  logic [LW-1:0] sel [MAX_EXTENTS];
  ffea_flags_t   edge_fl;

  // request decode
  logic [CW-1:0] need_c, s_c, rem_c, rlen_c, cfg_c;
  logic [PW-1:0] off_wide;
  logic          in_acc, cfg_acc, out_free, full, found;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_free = !out_valid || !out_stall;
  assign full     = fl[MAX_EXTENTS-1].valid;
  assign found    = fl[MAX_EXTENTS-1].fitpre;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  always_comb begin
    // round up in a sum one bit wider than the byte size
    need_c = CW'(((SIZE_W + 1)'(size_bytes) + (SIZE_W + 1)'(GRANULE_BYTES - 1)) >> GL);
    s_c    = CW'(block_offset >> GL);
    rem_c  = CW'(region) - s_c;
    rlen_c = (need_c > rem_c) ? rem_c : need_c;
    cfg_c  = CW'(cfg_data);
    if (cfg_c == '0) cfg_c = CW'(1);
    if (cfg_c > CW'(MAX_GRAN)) cfg_c = CW'(MAX_GRAN);
    init_len = rst ? LW'(RESET_G) : cfg_c[LW-1:0];
    off_wide = PW'(sel[MAX_EXTENTS-1]) << GL;
  end

  // left edge of the row: "everything before starts at or below s"
  always_comb begin
    edge_fl    = '0;
    edge_fl.le = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (need_c == '0) state_next = ST_DONE;
          else if (kind == KIND_ALLOC) state_next = ST_ALLOC;
          else if (s_c >= CW'(region)) state_next = ST_DONE;
          else state_next = ST_PROBE;
        end
      end
      ST_ALLOC: state_next = ST_DONE;
      ST_PROBE: state_next = (!fl[MAX_EXTENTS-1].merge_any && full) ? ST_DONE : ST_PLACE;
      ST_PLACE: state_next = ST_MERGE;
      ST_MERGE: state_next = fl[MAX_EXTENTS-1].absorb_any ? ST_MERGE : ST_DONE;
      ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // command to the cell row
  always_comb begin
    cmd = CMD_NONE;
    unique case (state)
      ST_IDLE:  cmd = cfg_acc ? CMD_INIT : CMD_NONE;
      ST_ALLOC: cmd = CMD_ALLOC;
      ST_PLACE: cmd = CMD_PLACE;
      ST_MERGE: cmd = CMD_MERGE;
      default:  cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      region    <= LW'(RESET_G);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) region <= cfg_c[LW-1:0];
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // request registers and result capture
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      need_r     <= (need_c > CW'(MAX_GRAN)) ? (LW + 1)'(MAX_GRAN + 1) : need_c[LW:0];
      s_r        <= s_c[LW-1:0];
      rlen_r     <= rlen_c[LW-1:0];
      e_r        <= s_c[LW-1:0] + rlen_c[LW-1:0];
      res_status <= (need_c == '0) ? STAT_ZERO : STAT_OK;
      res_off    <= '0;
    end
    if (state == ST_ALLOC) begin
      res_status <= found ? STAT_OK : STAT_NOFIT;
      res_off    <= found ? off_wide[OFFSET_W-1:0] : '0;
    end
    if (state == ST_PROBE && !fl[MAX_EXTENTS-1].merge_any && full) begin
      res_status <= STAT_FULL;
    end
    if (state == ST_DONE && out_free) begin
      status         <= res_status;
      granted_offset <= res_off;
    end
  end

  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    ffea_cell #(
      .LW       (LW),
      .IS_FIRST (i == 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .init_len (init_len),
      .need     (need_r),
      .rel_s    (s_r),
      .rel_e    (e_r),
      .rel_len  (rlen_r),
      .l_fl     ((i == 0) ? edge_fl : fl[(i == 0) ? 0 : i - 1]),
      .l_start  ((i == 0) ? '0 : cst[(i == 0) ? 0 : i - 1]),
      .l_len    ((i == 0) ? '0 : cln[(i == 0) ? 0 : i - 1]),
      .r_valid  ((i == MAX_EXTENTS - 1) ? 1'b0 :
                 fl[(i == MAX_EXTENTS - 1) ? i : i + 1].valid),
      .r_start  ((i == MAX_EXTENTS - 1) ? '0 : cst[(i == MAX_EXTENTS - 1) ? i : i + 1]),
      .r_len    ((i == MAX_EXTENTS - 1) ? '0 : cln[(i == MAX_EXTENTS - 1) ? i : i + 1]),
      .sel_in   ((i == 0) ? '0 : sel[(i == 0) ? 0 : i - 1]),
      .o_fl     (fl[i]),
      .o_start  (cst[i]),
      .o_len    (cln[i]),
      .sel_out  (sel[i])
    );
  end

  // a region write leaves exactly one extent, in the first cell
  a_init: assert property (@(posedge clk) disable iff (rst)
    cfg_acc |=> (fl[0].valid && !fl[MAX_EXTENTS-1].valid))
    else $error("table not re-initialized by region write");

  // an insert is only placed when there is room or a neighbor absorbs it
  a_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLACE) |-> (fl[MAX_EXTENTS-1].merge_any || !full))
    else $error("insert into full table");

  // allocate finishes in one step of the row
  a_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC) |=> (state == ST_DONE))
    else $error("allocate did not finish");

endmodule

/* verif/tb_first_fit_extent_allocator_unit.sv */
module tb_first_fit_extent_allocator_unit;
  import ffea_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEXT = MAX_EXTENTS_DEF;
  localparam int GRAN = GRANULE_BYTES_DEF;
  localparam int MAXG = REGION_BYTES_DEF / GRANULE_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  // free-extent table mirror plus queue of expected status/offset pairs
  class extent_scoreboard;
    int unsigned region;
    int unsigned ext_start[NEXT];
    int unsigned ext_len[NEXT];
    int unsigned count;
    ffea_status_e exp_status[$];
    logic [OFFSET_W-1:0] exp_offset[$];
    int errors;

    function void init_table(int unsigned granules);
      region = granules;
      for (int i = 0; i < NEXT; i++) begin
        ext_start[i] = 0;
        ext_len[i] = 0;
      end
      ext_len[0] = granules;
      count = 1;
    endfunction

    function void drop(int unsigned i);
      for (int unsigned k = i; k + 1 < count; k++) begin
        ext_start[k] = ext_start[k+1];
        ext_len[k] = ext_len[k+1];
      end
      count--;
      ext_start[count] = 0;
      ext_len[count] = 0;
    endfunction

    function ffea_status_e take_first_fit(int unsigned need, output int unsigned off);
      off = 0;
      for (int unsigned i = 0; i < count; i++) begin
        if (ext_len[i] == need) begin
          off = ext_start[i] * GRAN;
          drop(i);
          return STAT_OK;
        end
        if (ext_len[i] > need) begin
          off = ext_start[i] * GRAN;
          ext_start[i] += need;
          ext_len[i] -= need;
          return STAT_OK;
        end
      end
      return STAT_NOFIT;
    endfunction

    function ffea_status_e give_back(int unsigned s, int unsigned len);
      int unsigned p, idx, e, ce, ne;
      p = 0;
      if (s >= region) return STAT_OK;
      if (len > region - s) len = region - s;
      e = s + len;
      while (p < count && ext_start[p] <= s) p++;
      if (p > 0 && ext_start[p-1] + ext_len[p-1] >= s) begin
        idx = p - 1;
        if (e > ext_start[idx] + ext_len[idx]) ext_len[idx] = e - ext_start[idx];
      end else if (p < count && e >= ext_start[p]) begin
        idx = p;
        ne = ext_start[p] + ext_len[p];
        if (ne > e) e = ne;
        ext_start[idx] = s;
        ext_len[idx] = e - s;
      end else begin
        if (count >= NEXT) return STAT_FULL;
        for (int unsigned k = count; k > p; k--) begin
          ext_start[k] = ext_start[k-1];
          ext_len[k] = ext_len[k-1];
        end
        ext_start[p] = s;
        ext_len[p] = len;
        count++;
        idx = p;
      end
      // absorb following extents that now touch or overlap
      while (idx + 1 < count && ext_start[idx] + ext_len[idx] >= ext_start[idx+1]) begin
        ce = ext_start[idx] + ext_len[idx];
        ne = ext_start[idx+1] + ext_len[idx+1];
        if (ne > ce) ext_len[idx] = ne - ext_start[idx];
        drop(idx + 1);
      end
      return STAT_OK;
    endfunction

    function void note_request(logic k, logic [SIZE_W-1:0] sz, logic [OFFSET_W-1:0] boff);
      int unsigned need, off;
      ffea_status_e st;
      need = (int'(sz) + GRAN - 1) / GRAN;
      off = 0;
      if (need == 0) st = STAT_ZERO;
      else if (k == KIND_ALLOC) st = take_first_fit(need, off);
      else st = give_back(int'(boff) / GRAN, need);
      if (st != STAT_OK || k != KIND_ALLOC) off = 0;
      exp_status.push_back(st);
      exp_offset.push_back(off[OFFSET_W-1:0]);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [OFFSET_W-1:0] off);
      if (exp_status.size() == 0) begin
        $display("%0t: unexpected result status=%0d offset=%0h", $time, st, off);
        errors++;
        return;
      end
      if (st !== exp_status[0]) begin
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, exp_status[0], st);
        errors++;
      end
      if (off !== exp_offset[0]) begin
        $display("%0t: granted_offset mismatch expected=%0h actual=%0h",
                 $time, exp_offset[0], off);
        errors++;
      end
      void'(exp_status.pop_front());
      void'(exp_offset.pop_front());
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_stall, kind;
  logic [SIZE_W-1:0] size_bytes;
  logic [OFFSET_W-1:0] block_offset;
  logic out_valid, out_stall;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] granted_offset;

  extent_scoreboard sb;
  int idle_cycles;
  bit sink_quiet;
  logic [OFFSET_W-1:0] held_blocks[$];
  logic [SIZE_W-1:0] held_sizes[$];

  first_fit_extent_allocator_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .size_bytes(size_bytes), .block_offset(block_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .granted_offset(granted_offset)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: random stall, check at accepted edges
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(status, granted_offset);
      if (sink_quiet) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  // watchdog on cycles with no accepted request, result or write
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(logic k, logic [SIZE_W-1:0] sz, logic [OFFSET_W-1:0] boff);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    size_bytes <= sz;
    block_offset <= boff;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(k, sz, boff);
    // valid stays high so a request with no gap follows directly
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.exp_status.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_region(logic [CFG_W-1:0] v);
    int unsigned g;
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    g = v;
    if (g < 1) g = 1;
    if (g > MAXG) g = MAXG;
    sb.init_table(g);
    held_blocks.delete();
    held_sizes.delete();
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 70) return $urandom_range(1, 256);
    if (r < 93) return $urandom_range(1, 8192);
    return $urandom_range(0, 2097151);
  endfunction

  // allocate, remembering what was granted so it can be given back later
  task automatic alloc_tracked(logic [SIZE_W-1:0] sz);
    int n;
    send_request(KIND_ALLOC, sz, $urandom_range(0, 1048575));
    // the request just noted is the newest entry of the queue
    n = sb.exp_status.size() - 1;
    if (sb.exp_status[n] == STAT_OK) begin
      held_blocks.push_back(sb.exp_offset[n]);
      held_sizes.push_back(sz);
    end
  endtask

  task automatic random_phase(int n, int fragment);
    int r, i;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45 || held_blocks.size() == 0) begin
        alloc_tracked(rand_size());
      end else if (r < 85) begin
        int j;
        j = $urandom_range(0, held_blocks.size() - 1);
        // fragment phases release only every other block to fill the table
        if (fragment && (j % 2 == 1)) j = j - 1;
        send_request(KIND_RELEASE, held_sizes[j], held_blocks[j]);
        held_blocks.delete(j);
        held_sizes.delete(j);
      end else begin
        // noise: random release, possibly overlapping or beyond the region
        send_request(KIND_RELEASE, rand_size(), $urandom_range(0, 1048575));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.init_table(RESET_GRANULES > MAXG ? MAXG : RESET_GRANULES);
    sink_quiet = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_ALLOC;
    size_bytes = '0;
    block_offset = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero sizes, odd sizes, exact fit, no fit, merges, overlap, beyond end
    send_request(KIND_ALLOC, 0, 20'hFFFFF);
    send_request(KIND_RELEASE, 0, 0);
    send_request(KIND_ALLOC, 1, 0);
    send_request(KIND_ALLOC, 17, 0);
    send_request(KIND_ALLOC, 2097151, 0);
    send_request(KIND_ALLOC, 1048576, 0);
    send_request(KIND_RELEASE, 16, 0);
    send_request(KIND_RELEASE, 32, 16);
    send_request(KIND_RELEASE, 1048576, 20'hFFFFF);
    send_request(KIND_ALLOC, 1048576, 0);
    send_request(KIND_ALLOC, 1, 0);
    send_request(KIND_RELEASE, 2097151, 20'h00010);
    write_region(0);
    send_request(KIND_ALLOC, 16, 0);
    send_request(KIND_ALLOC, 16, 0);
    send_request(KIND_RELEASE, 16, 32);
    send_request(KIND_RELEASE, 16, 0);
    write_region(17'h1FFFF);
    send_request(KIND_ALLOC, 64, 0);
    send_request(KIND_ALLOC, 64, 0);
    send_request(KIND_ALLOC, 64, 0);
    send_request(KIND_RELEASE, 64, 0);
    send_request(KIND_RELEASE, 64, 128);
    send_request(KIND_RELEASE, 64, 64);
    send_request(KIND_RELEASE, 100, 8);

    random_phase(350, 0);
    write_region(300);
    random_phase(300, 1);
    write_region(1);
    random_phase(60, 0);
    write_region($urandom_range(2, 131071));
    // table-full pressure: many small grants, then every other one back
    for (int i = 0; i < 80; i++) alloc_tracked(16);
    random_phase(300, 1);
    write_region(65536);
    random_phase(360, 0);

    sink_quiet = 1'b1;
    drain();
    if (sb.errors == 0 && sb.exp_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
